[sv/gta_pkg.sv]
// Shared constants, type codes and class mapping for the greedy track association block.
// Depends on nothing; imported by the top level and the testbench.
`default_nettype none
package gta_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned VEL_W    = 14;
  localparam int unsigned LOST_W   = 8;
  localparam int unsigned RADIUS_W = 13;
  localparam int unsigned MLF_W    = 8;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned LIM_W    = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOST     = 1'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd50;
  localparam logic [MLF_W-1:0]    MLF_RESET    = 8'd5;

  localparam logic [LOST_W-1:0] LOST_MAX = 8'd255;
  localparam int VEL_LIMIT = 8190;

  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN    = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_BICYCLE    = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_CAR        = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_MOTORCYCLE = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_BUS        = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_TRUCK      = 3'd5;

  localparam logic [CLASS_W-1:0] CLASS_BICYCLE    = 8'd1;
  localparam logic [CLASS_W-1:0] CLASS_CAR        = 8'd2;
  localparam logic [CLASS_W-1:0] CLASS_MOTORCYCLE = 8'd3;
  localparam logic [CLASS_W-1:0] CLASS_BUS        = 8'd5;
  localparam logic [CLASS_W-1:0] CLASS_TRUCK      = 8'd7;

  localparam logic ACT_DETECT = 1'b0;
  localparam logic ACT_FRAME  = 1'b1;

  function automatic logic [TYPE_W-1:0] class_to_type(input logic [CLASS_W-1:0] c);
    logic [TYPE_W-1:0] t;
    case (c)
      CLASS_BICYCLE:    t = TYPE_BICYCLE;
      CLASS_CAR:        t = TYPE_CAR;
      CLASS_MOTORCYCLE: t = TYPE_MOTORCYCLE;
      CLASS_BUS:        t = TYPE_BUS;
      CLASS_TRUCK:      t = TYPE_TRUCK;
      default:          t = TYPE_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[sv/gta_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
// Used for the detection buffer and the track table; no package needed.
`default_nettype none
module gta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[sv/gta_dist.sv]
// Two-stage squared centre distance unit: absolute differences, then squares.
// Sum of squares is given combinationally from the registered squares.
`default_nettype none
module gta_dist #(
  parameter int unsigned CW = 14
) (
  input  wire logic          clk_i,
  input  wire logic [CW-1:0] dcx_i,
  input  wire logic [CW-1:0] dcy_i,
  input  wire logic [CW-1:0] tcx_i,
  input  wire logic [CW-1:0] tcy_i,
  output logic      [2*CW:0] d2_o
);

  logic [CW-1:0]   ax_q, ay_q;
  logic [2*CW-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    ax_q  <= (dcx_i >= tcx_i) ? dcx_i - tcx_i : tcx_i - dcx_i;
    ay_q  <= (dcy_i >= tcy_i) ? dcy_i - tcy_i : tcy_i - dcy_i;
    sqx_q <= (2*CW)'(ax_q) * (2*CW)'(ax_q);
    sqy_q <= (2*CW)'(ay_q) * (2*CW)'(ay_q);
  end

  assign d2_o = {1'b0, sqx_q} + {1'b0, sqy_q};

endmodule
`default_nettype wire

[sv/greedy_track_association.sv]
// Greedy nearest-neighbour track association: top level with the frame sequencer.
// Depends on gta_pkg, gta_ram and gta_dist.
//
// A detection request (action 0) is taken while idle and busy_o stays low. An
// end-of-frame request raises busy_o until its last result has been shown. The
// sequencer walks the track table memory one slot per cycle: each track is found in
// id order by a full scan, then each buffered detection passes through the distance
// pipeline, then the track is written back; a closing search finds no further track.
// Ageing is one more scan; each new track costs a scan for its id or a free slot and
// a write, and each matched detection is skipped; each result costs a scan. Results
// appear one at a time on res_valid_o for a single cycle each and cannot be stalled;
// last_o marks the final one of the frame.
`default_nettype none
module greedy_track_association #(
  parameter int unsigned MAX_TRACKS     = 16,
  parameter int unsigned MAX_DETECTIONS = 16,
  parameter int unsigned COORD_BITS     = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          action_i,
  input  wire logic [COORD_BITS-1:0]         box_x_i,
  input  wire logic [COORD_BITS-1:0]         box_y_i,
  input  wire logic [COORD_BITS-1:0]         box_w_i,
  input  wire logic [COORD_BITS-1:0]         box_h_i,
  input  wire logic [gta_pkg::CLASS_W-1:0]   class_code_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [gta_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gta_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                               res_valid_o,
  output logic                               track_valid_o,
  output logic [gta_pkg::ID_W-1:0]           trk_id_o,
  output logic [gta_pkg::TYPE_W-1:0]         track_type_o,
  output logic [COORD_BITS-1:0]              out_x_o,
  output logic [COORD_BITS-1:0]              out_y_o,
  output logic [COORD_BITS-1:0]              out_w_o,
  output logic [COORD_BITS-1:0]              out_h_o,
  output logic signed [gta_pkg::VEL_W-1:0]   vel_x_o,
  output logic signed [gta_pkg::VEL_W-1:0]   vel_y_o,
  output logic [gta_pkg::LOST_W-1:0]         lost_count_o,
  output logic                               overflow_o,
  output logic                               last_o
);
  import gta_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned CW   = CB + 2;
  localparam int unsigned D2W  = 2 * CW + 1;
  localparam int unsigned CMPW = (D2W > LIM_W) ? D2W : LIM_W;
  localparam int unsigned AW   = $clog2(MAX_TRACKS);
  localparam int unsigned DAW  = $clog2(MAX_DETECTIONS);
  localparam int unsigned CNTW = $clog2(MAX_DETECTIONS + 1);
  localparam int unsigned LVW  = $clog2(MAX_TRACKS + 1);
  localparam int unsigned DETW = 4 * CB + TYPE_W;
  localparam int unsigned TRW  = ID_W + TYPE_W + 4 * CB + 2 * VEL_W + LOST_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASEL  = 4'd1;
  localparam logic [3:0] S_DRD   = 4'd2;
  localparam logic [3:0] S_DDIFF = 4'd3;
  localparam logic [3:0] S_DSQ   = 4'd4;
  localparam logic [3:0] S_DCMP  = 4'd5;
  localparam logic [3:0] S_AUPD  = 4'd6;
  localparam logic [3:0] S_AWR   = 4'd7;
  localparam logic [3:0] S_RMV   = 4'd8;
  localparam logic [3:0] S_NCHK  = 4'd9;
  localparam logic [3:0] S_NSCAN = 4'd10;
  localparam logic [3:0] S_NWR   = 4'd11;
  localparam logic [3:0] S_ESEL  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [RADIUS_W-1:0] radius_q;
  logic [MLF_W-1:0] mlf_q;
  logic [LIM_W-1:0] lim_q;
  logic [CNTW-1:0] det_cnt_q, det_cnt_d;
  logic ovf_q, ovf_d;
  logic [ID_W-1:0] next_id_q, next_id_d;
  logic [MAX_TRACKS-1:0] valid_q, valid_d;
  logic [LVW-1:0] live_q, live_d, emit_k_q, emit_k_d;
  logic [MAX_DETECTIONS-1:0] used_q, used_d;
  logic [AW:0] scan_a_q, scan_a_d;
  logic rv_q, rv_d;
  logic [AW-1:0] rs_q, rs_d, sel_q, sel_d;
  logic found_q, found_d, first_q, first_d;
  logic [ID_W-1:0] prev_id_q, prev_id_d;
  logic [ID_W-1:0] cur_id_q;
  logic [TYPE_W-1:0] cur_type_q;
  logic [CB-1:0] cur_x_q, cur_y_q, cur_w_q, cur_h_q;
  logic [VEL_W-1:0] cur_vx_q, cur_vy_q;
  logic [LOST_W-1:0] cur_lost_q;
  logic cur_load;
  logic [CNTW-1:0] di_q, di_d;
  logic [DAW-1:0] bi_q, bi_d;
  logic afound_q, afound_d, elig_q, elig_d;
  logic [D2W-1:0] best_q, best_d;
  logic emit_fire, empty_fire, scan_init;

  // memories
  logic det_we;
  logic [DAW-1:0] det_raddr;
  logic [DETW-1:0] det_rdata;
  logic trk_we;
  logic [AW-1:0] trk_waddr;
  logic [TRW-1:0] trk_wdata, trk_rdata;

  gta_ram #(.WIDTH(DETW), .DEPTH(MAX_DETECTIONS)) u_det_ram (
    .clk_i   (clk_i),
    .we_i    (det_we),
    .waddr_i (det_cnt_q[DAW-1:0]),
    .wdata_i ({box_x_i, box_y_i, box_w_i, box_h_i, class_to_type(class_code_i)}),
    .raddr_i (det_raddr),
    .rdata_o (det_rdata)
  );

  gta_ram #(.WIDTH(TRW), .DEPTH(MAX_TRACKS)) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_waddr),
    .wdata_i (trk_wdata),
    .raddr_i (scan_a_q[AW-1:0]),
    .rdata_o (trk_rdata)
  );

  logic [CB-1:0] dx, dy, dw, dh;
  logic [TYPE_W-1:0] dtype;
  assign {dx, dy, dw, dh, dtype} = det_rdata;

  logic [ID_W-1:0] r_id;
  logic [TYPE_W-1:0] r_type;
  logic [CB-1:0] r_x, r_y, r_w, r_h;
  logic [VEL_W-1:0] r_vx, r_vy;
  logic [LOST_W-1:0] r_lost;
  assign {r_id, r_type, r_x, r_y, r_w, r_h, r_vx, r_vy, r_lost} = trk_rdata;

  // doubled centres
  logic [CW-1:0] dcx, dcy, tcx, tcy;
  assign dcx = CW'({dx, 1'b0}) + CW'(dw);
  assign dcy = CW'({dy, 1'b0}) + CW'(dh);
  assign tcx = CW'({cur_x_q, 1'b0}) + CW'(cur_w_q);
  assign tcy = CW'({cur_y_q, 1'b0}) + CW'(cur_h_q);

  logic [D2W-1:0] d2;
  gta_dist #(.CW(CW)) u_dist (
    .clk_i (clk_i),
    .dcx_i (dcx),
    .dcy_i (dcy),
    .tcx_i (tcx),
    .tcy_i (tcy),
    .d2_o  (d2)
  );

  logic signed [CW:0] vdx, vdy;
  logic signed [31:0] vdx_w, vdy_w;
  logic [VEL_W-1:0] nvx, nvy;
  assign vdx = $signed({1'b0, dcx}) - $signed({1'b0, tcx});
  assign vdy = $signed({1'b0, dcy}) - $signed({1'b0, tcy});
  assign vdx_w = 32'(vdx);
  assign vdy_w = 32'(vdy);
  always_comb begin
    if (vdx_w > VEL_LIMIT) nvx = VEL_W'(VEL_LIMIT);
    else if (vdx_w < -VEL_LIMIT) nvx = VEL_W'(-VEL_LIMIT);
    else nvx = vdx_w[VEL_W-1:0];
    if (vdy_w > VEL_LIMIT) nvy = VEL_W'(VEL_LIMIT);
    else if (vdy_w < -VEL_LIMIT) nvy = VEL_W'(-VEL_LIMIT);
    else nvy = vdy_w[VEL_W-1:0];
  end

  // first free slot
  logic [AW-1:0] free_slot;
  logic free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int s = MAX_TRACKS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_slot = AW'(s);
        free_any  = 1'b1;
      end
    end
  end

  logic scan_done, better;
  assign scan_done = (scan_a_q == (AW+1)'(MAX_TRACKS)) && !rv_q;
  assign better = rv_q && valid_q[rs_q] && (first_q || r_id > prev_id_q)
                  && (!found_q || r_id < cur_id_q);

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    det_cnt_d = det_cnt_q;
    ovf_d = ovf_q;
    next_id_d = next_id_q;
    valid_d = valid_q;
    live_d = live_q;
    emit_k_d = emit_k_q;
    used_d = used_q;
    scan_a_d = scan_a_q;
    rv_d = 1'b0;
    rs_d = rs_q;
    sel_d = sel_q;
    found_d = found_q;
    first_d = first_q;
    prev_id_d = prev_id_q;
    di_d = di_q;
    bi_d = bi_q;
    afound_d = afound_q;
    elig_d = elig_q;
    best_d = best_q;
    cur_load = 1'b0;
    emit_fire = 1'b0;
    empty_fire = 1'b0;
    scan_init = 1'b0;
    det_we = 1'b0;
    det_raddr = di_q[DAW-1:0];
    trk_we = 1'b0;
    trk_waddr = sel_q;
    trk_wdata = {cur_id_q, cur_type_q, cur_x_q, cur_y_q, cur_w_q, cur_h_q,
                 cur_vx_q, cur_vy_q, cur_lost_q};

    if (scan_a_q != (AW+1)'(MAX_TRACKS)) begin
      scan_a_d = scan_a_q + 1'b1;
      rv_d = 1'b1;
      rs_d = scan_a_q[AW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        rv_d = 1'b0;
        scan_a_d = scan_a_q;
        if (accept) begin
          if (action_i == ACT_DETECT) begin
            if (det_cnt_q == CNTW'(MAX_DETECTIONS)) begin
              ovf_d = 1'b1;
            end else begin
              det_we = 1'b1;
              det_cnt_d = det_cnt_q + 1'b1;
            end
          end else begin
            used_d = '0;
            first_d = 1'b1;
            scan_init = 1'b1;
            state_d = S_ASEL;
          end
        end
      end
      S_ASEL, S_ESEL: begin
        if (better) begin
          cur_load = 1'b1;
          found_d = 1'b1;
          sel_d = rs_q;
        end
        if (scan_done) begin
          if (state_q == S_ASEL) begin
            if (!found_q) begin
              scan_init = 1'b1;
              state_d = S_RMV;
            end else begin
              di_d = '0;
              afound_d = 1'b0;
              state_d = (det_cnt_q == '0) ? S_AUPD : S_DRD;
            end
          end else begin
            emit_fire = 1'b1;
            if (emit_k_q == live_q - 1'b1) begin
              det_cnt_d = '0;
              ovf_d = 1'b0;
              state_d = S_IDLE;
            end else begin
              emit_k_d = emit_k_q + 1'b1;
              prev_id_d = cur_id_q;
              first_d = 1'b0;
              scan_init = 1'b1;
            end
          end
        end
      end
      S_DRD: begin
        state_d = S_DDIFF;
      end
      S_DDIFF: begin
        elig_d = !used_q[di_q[DAW-1:0]] && (cur_type_q == TYPE_UNKNOWN || cur_type_q == dtype);
        state_d = S_DSQ;
      end
      S_DSQ: begin
        state_d = S_DCMP;
      end
      S_DCMP: begin
        if (elig_q && CMPW'(d2) < CMPW'(lim_q) && (!afound_q || d2 < best_q)) begin
          afound_d = 1'b1;
          best_d = d2;
          bi_d = di_q[DAW-1:0];
        end
        if (di_q + 1'b1 == det_cnt_q) begin
          state_d = S_AUPD;
        end else begin
          di_d = di_q + 1'b1;
          state_d = S_DRD;
        end
      end
      S_AUPD: begin
        det_raddr = bi_q;
        if (afound_q) begin
          state_d = S_AWR;
        end else begin
          trk_we = 1'b1;
          trk_wdata[LOST_W-1:0] = (cur_lost_q == LOST_MAX) ? cur_lost_q : cur_lost_q + 1'b1;
          prev_id_d = cur_id_q;
          first_d = 1'b0;
          scan_init = 1'b1;
          state_d = S_ASEL;
        end
      end
      S_AWR: begin
        trk_we = 1'b1;
        trk_wdata = {cur_id_q, (cur_type_q == TYPE_UNKNOWN) ? dtype : cur_type_q,
                     dx, dy, dw, dh, nvx, nvy, LOST_W'(0)};
        used_d[bi_q] = 1'b1;
        prev_id_d = cur_id_q;
        first_d = 1'b0;
        scan_init = 1'b1;
        state_d = S_ASEL;
      end
      S_RMV: begin
        if (rv_q && valid_q[rs_q] && r_lost > mlf_q) begin
          valid_d[rs_q] = 1'b0;
          live_d = live_q - 1'b1;
        end
        if (scan_done) begin
          di_d = '0;
          state_d = S_NCHK;
        end
      end
      S_NCHK: begin
        rv_d = 1'b0;
        scan_a_d = scan_a_q;
        if (di_q == det_cnt_q) begin
          if (live_q == '0) begin
            empty_fire = 1'b1;
            det_cnt_d = '0;
            ovf_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            emit_k_d = '0;
            first_d = 1'b1;
            scan_init = 1'b1;
            state_d = S_ESEL;
          end
        end else if (used_q[di_q[DAW-1:0]]) begin
          di_d = di_q + 1'b1;
        end else begin
          scan_init = 1'b1;
          state_d = S_NSCAN;
        end
      end
      S_NSCAN: begin
        if (rv_q && valid_q[rs_q] && r_id == next_id_q && !found_q) begin
          found_d = 1'b1;
          sel_d = rs_q;
        end
        if (scan_done) begin
          if (found_q) begin
            state_d = S_NWR;
          end else if (free_any) begin
            sel_d = free_slot;
            state_d = S_NWR;
          end else begin
            ovf_d = 1'b1;
            di_d = di_q + 1'b1;
            state_d = S_NCHK;
          end
        end
      end
      S_NWR: begin
        trk_we = 1'b1;
        trk_wdata = {next_id_q, dtype, dx, dy, dw, dh, VEL_W'(0), VEL_W'(0), LOST_W'(0)};
        if (!valid_q[sel_q]) begin
          live_d = live_q + 1'b1;
        end
        valid_d[sel_q] = 1'b1;
        next_id_d = next_id_q + 1'b1;
        di_d = di_q + 1'b1;
        state_d = S_NCHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (scan_init) begin
      scan_a_d = '0;
      rv_d = 1'b0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      radius_q <= RADIUS_RESET;
      mlf_q <= MLF_RESET;
      det_cnt_q <= '0;
      ovf_q <= 1'b0;
      next_id_q <= '0;
      valid_q <= '0;
      live_q <= '0;
      emit_k_q <= '0;
      used_q <= '0;
      scan_a_q <= '0;
      rv_q <= 1'b0;
      found_q <= 1'b0;
      first_q <= 1'b0;
      afound_q <= 1'b0;
      elig_q <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MATCH_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
          CFG_MAX_LOST:     mlf_q <= cfg_data_i[MLF_W-1:0];
          default: ;
        endcase
      end
      det_cnt_q <= det_cnt_d;
      ovf_q <= ovf_d;
      next_id_q <= next_id_d;
      valid_q <= valid_d;
      live_q <= live_d;
      emit_k_q <= emit_k_d;
      used_q <= used_d;
      scan_a_q <= scan_a_d;
      rv_q <= rv_d;
      found_q <= found_d;
      first_q <= first_d;
      afound_q <= afound_d;
      elig_q <= elig_d;
      res_valid_o <= emit_fire || empty_fire;
    end
  end

  logic [2*RADIUS_W-1:0] rr;
  assign rr = (2*RADIUS_W)'(radius_q) * (2*RADIUS_W)'(radius_q);

  always_ff @(posedge clk_i) begin
    lim_q <= {rr, 2'b00};
    rs_q <= rs_d;
    sel_q <= sel_d;
    prev_id_q <= prev_id_d;
    di_q <= di_d;
    bi_q <= bi_d;
    best_q <= best_d;
    if (cur_load) begin
      cur_id_q <= r_id;
      cur_type_q <= r_type;
      cur_x_q <= r_x;
      cur_y_q <= r_y;
      cur_w_q <= r_w;
      cur_h_q <= r_h;
      cur_vx_q <= r_vx;
      cur_vy_q <= r_vy;
      cur_lost_q <= r_lost;
    end
    if (emit_fire) begin
      track_valid_o <= 1'b1;
      trk_id_o <= cur_id_q;
      track_type_o <= cur_type_q;
      out_x_o <= cur_x_q;
      out_y_o <= cur_y_q;
      out_w_o <= cur_w_q;
      out_h_o <= cur_h_q;
      vel_x_o <= cur_vx_q;
      vel_y_o <= cur_vy_q;
      lost_count_o <= cur_lost_q;
      overflow_o <= ovf_q;
      last_o <= (emit_k_q == live_q - 1'b1);
    end else if (empty_fire) begin
      track_valid_o <= 1'b0;
      trk_id_o <= '0;
      track_type_o <= TYPE_UNKNOWN;
      out_x_o <= '0;
      out_y_o <= '0;
      out_w_o <= '0;
      out_h_o <= '0;
      vel_x_o <= '0;
      vel_y_o <= '0;
      lost_count_o <= '0;
      overflow_o <= ovf_q;
      last_o <= 1'b1;
    end
  end

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(live_q))
    else $error("live track count disagrees with valid bits");

  a_det_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_cnt_q <= CNTW'(MAX_DETECTIONS))
    else $error("detection count beyond buffer depth");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> !busy_o)
    else $error("busy after last result of frame");

  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_FRAME) |=> busy_o)
    else $error("end-of-frame request did not start association");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o)
    else $error("result without last while idle");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for greedy_track_association: directed frames, then random frames under
// three sender idling regimes, each result checked against a local tracker predictor.
// Depends on gta_pkg and the greedy_track_association RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gta_pkg::*;

  localparam int NTRK = 16;
  localparam int NDET = 16;

  typedef struct {
    bit            valid;
    bit [15:0]     id;
    bit [2:0]      typ;
    bit [11:0]     x, y, w, h;
    int            vx, vy;
    bit [7:0]      lost;
  } trk_t;

  typedef struct {
    bit [11:0] x, y, w, h;
    bit [2:0]  typ;
  } det_t;

  typedef struct {
    bit        tvalid;
    bit [15:0] id;
    bit [2:0]  typ;
    bit [11:0] x, y, w, h;
    bit [13:0] vx, vy;
    bit [7:0]  lost;
    bit        ovf;
    bit        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic action_i = 1'b0;
  logic [11:0] box_x_i = '0, box_y_i = '0, box_w_i = '0, box_h_i = '0;
  logic [CLASS_W-1:0] class_code_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic busy_o, res_valid_o, track_valid_o, overflow_o, last_o;
  logic [ID_W-1:0] trk_id_o;
  logic [TYPE_W-1:0] track_type_o;
  logic [11:0] out_x_o, out_y_o, out_w_o, out_h_o;
  logic signed [VEL_W-1:0] vel_x_o, vel_y_o;
  logic [LOST_W-1:0] lost_count_o;

  trk_t      tracks[NTRK];
  det_t      frame_dets[NDET];
  int        det_count;
  bit [15:0] next_id;
  bit        ovf_flag;
  int        radius;
  int        max_lost;
  res_t      track_q[$];
  int        errors;
  int        items;
  int        idle_pct;

  greedy_track_association u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .box_x_i, .box_y_i, .box_w_i,
    .box_h_i, .class_code_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_valid_o,
    .track_valid_o, .trk_id_o, .track_type_o, .out_x_o, .out_y_o, .out_w_o,
    .out_h_o, .vel_x_o, .vel_y_o, .lost_count_o, .overflow_o, .last_o
  );

  always #1 clk_i = ~clk_i;

  function automatic bit [2:0] type_of(bit [7:0] c);
    case (c)
      CLASS_BICYCLE:    return TYPE_BICYCLE;
      CLASS_CAR:        return TYPE_CAR;
      CLASS_MOTORCYCLE: return TYPE_MOTORCYCLE;
      CLASS_BUS:        return TYPE_BUS;
      CLASS_TRUCK:      return TYPE_TRUCK;
      default:          return TYPE_UNKNOWN;
    endcase
  endfunction

  function automatic int clip_vel(longint v);
    if (v > VEL_LIMIT) return VEL_LIMIT;
    if (v < -VEL_LIMIT) return -VEL_LIMIT;
    return int'(v);
  endfunction

  function automatic int id_order(ref int ord[NTRK]);
    int n;
    int k;
    n = 0;
    for (int s = 0; s < NTRK; s++) begin
      if (!tracks[s].valid) continue;
      k = n;
      while (k > 0 && tracks[ord[k-1]].id > tracks[s].id) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = s;
      n++;
    end
    return n;
  endfunction

  task automatic associate_frame();
    int ord[NTRK];
    bit taken[NDET];
    int n, bi, slot, cnt;
    bit found;
    longint lim, best, tcx, tcy, dx, dy, d2;
    res_t r;
    lim = 4 * longint'(radius) * longint'(radius);
    foreach (taken[i]) taken[i] = 0;
    n = id_order(ord);
    for (int k = 0; k < n; k++) begin
      tcx = 2 * longint'(tracks[ord[k]].x) + tracks[ord[k]].w;
      tcy = 2 * longint'(tracks[ord[k]].y) + tracks[ord[k]].h;
      found = 0;
      best = 0;
      bi = 0;
      for (int i = 0; i < det_count; i++) begin
        if (taken[i]) continue;
        if (tracks[ord[k]].typ != TYPE_UNKNOWN && tracks[ord[k]].typ != frame_dets[i].typ)
          continue;
        dx = 2 * longint'(frame_dets[i].x) + frame_dets[i].w - tcx;
        dy = 2 * longint'(frame_dets[i].y) + frame_dets[i].h - tcy;
        d2 = dx * dx + dy * dy;
        if (d2 < lim && (!found || d2 < best)) begin
          found = 1;
          best = d2;
          bi = i;
        end
      end
      if (found) begin
        tracks[ord[k]].vx = clip_vel(2 * longint'(frame_dets[bi].x) + frame_dets[bi].w - tcx);
        tracks[ord[k]].vy = clip_vel(2 * longint'(frame_dets[bi].y) + frame_dets[bi].h - tcy);
        tracks[ord[k]].x = frame_dets[bi].x;
        tracks[ord[k]].y = frame_dets[bi].y;
        tracks[ord[k]].w = frame_dets[bi].w;
        tracks[ord[k]].h = frame_dets[bi].h;
        if (tracks[ord[k]].typ == TYPE_UNKNOWN) tracks[ord[k]].typ = frame_dets[bi].typ;
        tracks[ord[k]].lost = 0;
        taken[bi] = 1;
      end else if (tracks[ord[k]].lost != LOST_MAX) begin
        tracks[ord[k]].lost++;
      end
    end
    for (int s = 0; s < NTRK; s++)
      if (tracks[s].valid && tracks[s].lost > max_lost) tracks[s].valid = 0;
    for (int i = 0; i < det_count; i++) begin
      if (taken[i]) continue;
      slot = -1;
      for (int s = 0; s < NTRK; s++)
        if (slot < 0 && tracks[s].valid && tracks[s].id == next_id) slot = s;
      for (int s = 0; s < NTRK; s++)
        if (slot < 0 && !tracks[s].valid) slot = s;
      if (slot < 0) begin
        ovf_flag = 1;
        continue;
      end
      tracks[slot] = '{1'b1, next_id, frame_dets[i].typ, frame_dets[i].x, frame_dets[i].y,
                       frame_dets[i].w, frame_dets[i].h, 0, 0, 8'd0};
      next_id++;
    end
    n = id_order(ord);
    cnt = n > 0 ? n : 1;
    for (int k = 0; k < cnt; k++) begin
      r = '{default: '0};
      if (n > 0) begin
        r.tvalid = 1;
        r.id = tracks[ord[k]].id;
        r.typ = tracks[ord[k]].typ;
        r.x = tracks[ord[k]].x;
        r.y = tracks[ord[k]].y;
        r.w = tracks[ord[k]].w;
        r.h = tracks[ord[k]].h;
        r.vx = tracks[ord[k]].vx[13:0];
        r.vy = tracks[ord[k]].vy[13:0];
        r.lost = tracks[ord[k]].lost;
      end
      r.ovf = ovf_flag;
      r.last = (k == cnt - 1);
      track_q.insert(track_q.size(), r);
    end
    det_count = 0;
    ovf_flag = 0;
  endtask

  task automatic send_req(bit act, int x, int y, int w, int h, int cls);
    @(negedge clk_i);
    start_i = 1'b1;
    action_i = act;
    box_x_i = x[11:0];
    box_y_i = y[11:0];
    box_w_i = w[11:0];
    box_h_i = h[11:0];
    class_code_i = cls[7:0];
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    items++;
    if (act == ACT_FRAME) begin
      associate_frame();
    end else if (det_count >= NDET) begin
      ovf_flag = 1;
    end else begin
      frame_dets[det_count] = '{x[11:0], y[11:0], w[11:0], h[11:0], type_of(cls[7:0])};
      det_count++;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic det(int x, int y, int w, int h, int cls);
    send_req(ACT_DETECT, x, y, w, h, cls);
  endtask

  task automatic end_frame();
    send_req(ACT_FRAME, $urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (track_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_MATCH_RADIUS) radius = val;
    else max_lost = val;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (track_q.size() == 0) begin
        report_mismatch("unexpected result, trk_id", trk_id_o, -1);
      end else begin
        e = track_q.pop_front();
        if (track_valid_o !== e.tvalid) report_mismatch("track_valid", track_valid_o, e.tvalid);
        if (trk_id_o !== e.id) report_mismatch("trk_id", trk_id_o, e.id);
        if (track_type_o !== e.typ) report_mismatch("track_type", track_type_o, e.typ);
        if (out_x_o !== e.x) report_mismatch("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report_mismatch("out_y", out_y_o, e.y);
        if (out_w_o !== e.w) report_mismatch("out_w", out_w_o, e.w);
        if (out_h_o !== e.h) report_mismatch("out_h", out_h_o, e.h);
        if (vel_x_o !== e.vx) report_mismatch("vel_x", vel_x_o, e.vx);
        if (vel_y_o !== e.vy) report_mismatch("vel_y", vel_y_o, e.vy);
        if (lost_count_o !== e.lost) report_mismatch("lost_count", lost_count_o, e.lost);
        if (overflow_o !== e.ovf) report_mismatch("overflow", overflow_o, e.ovf);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  // empty frame, extremes, every class, matching, type adoption, velocity clip
  task automatic test_directed();
    idle_pct = 29;
    end_frame();
    det(0, 0, 0, 0, CLASS_BICYCLE);
    det(4095, 4095, 4095, 4095, CLASS_CAR);
    det(1000, 1000, 40, 40, 0);
    det(2000, 500, 20, 20, CLASS_MOTORCYCLE);
    det(3000, 3000, 10, 10, CLASS_BUS);
    det(100, 3500, 60, 30, CLASS_TRUCK);
    det(2048, 2048, 2048, 2048, 255);
    end_frame();
    det(1010, 995, 40, 40, CLASS_TRUCK);
    det(2005, 505, 20, 20, CLASS_CAR);
    det(3004, 2998, 10, 10, CLASS_BUS);
    end_frame();
    wait_idle();
    write_cfg(CFG_MATCH_RADIUS, 8191);
    det(4095, 4095, 4095, 4095, CLASS_BICYCLE);
    det(0, 0, 0, 0, CLASS_CAR);
    end_frame();
  endtask

  // buffer overflow, table full, ageing out
  task automatic test_overflow();
    wait_idle();
    write_cfg(CFG_MATCH_RADIUS, 0);
    write_cfg(CFG_MAX_LOST, 255);
    for (int i = 0; i < 18; i++)
      det($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
          $urandom_range(0, 4095), $urandom_range(0, 255));
    end_frame();
    det(7, 7, 7, 7, CLASS_CAR);
    end_frame();
    wait_idle();
    write_cfg(CFG_MAX_LOST, 0);
    end_frame();
    end_frame();
  endtask

  function automatic int clamp(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  task automatic rand_frame(int max_dets);
    int n, s;
    int cls_pick[7] = '{0, 1, 2, 3, 5, 7, 4};
    n = ($urandom_range(0, 19) == 0) ? 17 : $urandom_range(0, max_dets);
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, NTRK - 1);
      if (tracks[s].valid && $urandom_range(0, 3) != 0)
        det(clamp(tracks[s].x + $urandom_range(0, 40) - 20),
            clamp(tracks[s].y + $urandom_range(0, 40) - 20),
            clamp(tracks[s].w + $urandom_range(0, 10) - 5),
            clamp(tracks[s].h + $urandom_range(0, 10) - 5),
            ($urandom_range(0, 2) == 0) ? cls_pick[$urandom_range(0, 6)] :
            (tracks[s].typ == TYPE_BUS ? CLASS_BUS : tracks[s].typ == TYPE_TRUCK ?
             CLASS_TRUCK : tracks[s].typ));
      else
        det($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom_range(0, 4095),
            $urandom_range(0, 1) ? $urandom_range(0, 255) : cls_pick[$urandom_range(0, 6)]);
    end
    end_frame();
  endtask

  task automatic test_random(int pct, int rad, int lost, int quota);
    int stop;
    wait_idle();
    idle_pct = pct;
    write_cfg(CFG_MATCH_RADIUS, rad);
    write_cfg(CFG_MAX_LOST, lost);
    stop = items + quota;
    while (items < stop) rand_frame(6);
  endtask

  initial begin
    errors = 0;
    items = 0;
    radius = RADIUS_RESET;
    max_lost = MLF_RESET;
    det_count = 0;
    next_id = 0;
    ovf_flag = 0;
    idle_pct = 0;
    foreach (tracks[s]) tracks[s] = '{default: '0};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow();
    test_random(29, 60, 3, 75);
    test_random(53, $urandom_range(1, 8190), 255, 75);
    test_random(0, 30, $urandom_range(1, 254), 75);
    test_random(0, 8191, 1, 65);
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

[greedy_track_association.f]
sv/gta_pkg.sv
sv/gta_ram.sv
sv/gta_dist.sv
sv/greedy_track_association.sv
tb/sv/tb.sv
